### sv/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg: shared types and codes for the ordered list engine
// Operation codes, status codes and field widths used by the core and memory.
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int DATA_W = 32;
	localparam int MODE_W = 3;
	localparam int STAT_W = 2;
	localparam int CNT_OUT_W = 5;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [STAT_W-1:0] stat_t;
	typedef logic [CNT_OUT_W-1:0] cnt_out_t;

	// operation codes
	localparam mode_t MODE_INS_FRONT = 3'd0;
	localparam mode_t MODE_INS_BACK = 3'd1;
	localparam mode_t MODE_INS_AFTER = 3'd2;
	localparam mode_t MODE_DEL_FRONT = 3'd3;
	localparam mode_t MODE_DEL_BACK = 3'd4;
	localparam mode_t MODE_DEL_KEY = 3'd5;

	// status codes
	localparam stat_t ST_OK = 2'd0;
	localparam stat_t ST_NOT_FOUND = 2'd1;
	localparam stat_t ST_EMPTY = 2'd2;
	localparam stat_t ST_FULL = 2'd3;

endpackage

### sv/ordered_list_engine_core.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_core: ordered list with insert and delete operations
// Entries sit packed from the front in a single-port-read memory; a small
// sequencer walks the memory one entry per cycle to search and to shift.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------
//  in      | in_valid / in_stall  | mode, value, key
//  out     | out_valid / out_stall| status, removed, entry_count
//
// Each transaction yields one result. An insert shifts the entries from
// position p to the back up by one before writing the new value, and a
// delete at p shifts the entries behind p down by one; keyed operations
// first walk the list from the front in a search. The longest case is a
// keyed delete, set by the one memory read port walked per cycle.
// in_stall is high from acceptance until the result is loaded into the
// output register; a stalled output holds the core in its finish step.
// Reset empties the list; the entry memory needs no clearing.
module ordered_list_engine_core #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ole_pkg::mode_t     mode,
	input  ole_pkg::data_t     value,
	input  ole_pkg::data_t     key,
	output logic               out_valid,
	input  logic               out_stall,
	output ole_pkg::stat_t     status,
	output ole_pkg::data_t     removed,
	output ole_pkg::cnt_out_t  entry_count
);
	import ole_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SRCH = 3'd1;
	localparam logic [2:0] S_INS = 3'd2;
	localparam logic [2:0] S_DEL = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	logic [2:0]    state_q;
	mode_t         mode_q;
	data_t         val_q;
	data_t         key_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] cmp_q;
	logic [CW-1:0] pos_q;
	logic          pend_q;
	data_t         removed_q;
	stat_t         status_q;
	logic          out_valid_q;
	stat_t         out_status_q;
	data_t         out_removed_q;
	cnt_out_t      out_count_q;

	logic          full;
	logic          empty;
	logic          issue;
	logic          hit;
	logic [CW-1:0] rd_idx;
	logic [CW-1:0] wr_idx;
	logic          we;
	data_t         wd;
	data_t         rd_data;

	assign full = (used_q == CW'(DEPTH));
	assign empty = (used_q == '0);
	assign hit = pend_q && (rd_data == key_q);

	// read address and read issue for the current step
	always_comb begin
		rd_idx = idx_q;
		issue = 1'b0;
		case (state_q)
			S_SRCH, S_DEL: begin
				issue = (idx_q < used_q);
			end
			S_INS: begin
				rd_idx = idx_q - CW'(1);
				issue = (idx_q > pos_q);
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	// write port: shift moves and the final insert
	always_comb begin
		we = 1'b0;
		wr_idx = cmp_q;
		wd = rd_data;
		case (state_q)
			S_INS: begin
				if (pend_q) begin
					we = 1'b1;
					wr_idx = cmp_q + CW'(1);
				end else if (!issue) begin
					we = 1'b1;
					wr_idx = pos_q;
					wd = val_q;
				end
			end
			S_DEL: begin
				if (pend_q && (cmp_q != pos_q)) begin
					we = 1'b1;
					wr_idx = cmp_q - CW'(1);
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	ole_ram #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(we),
		.wa(wr_idx[AW-1:0]),
		.wd(wd),
		.ra(rd_idx[AW-1:0]),
		.rd(rd_data)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			idx_q <= '0;
			cmp_q <= '0;
			pos_q <= '0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pend_q <= 1'b0;
						state_q <= S_FIN;
						case (mode)
							MODE_INS_FRONT, MODE_INS_BACK: begin
								if (!full) begin
									pos_q <= (mode == MODE_INS_FRONT) ? '0 : used_q;
									idx_q <= used_q;
									state_q <= S_INS;
								end
							end
							MODE_INS_AFTER: begin
								idx_q <= '0;
								state_q <= S_SRCH;
							end
							MODE_DEL_FRONT, MODE_DEL_BACK: begin
								if (!empty) begin
									pos_q <= (mode == MODE_DEL_FRONT) ? '0 : used_q - CW'(1);
									idx_q <= (mode == MODE_DEL_FRONT) ? '0 : used_q - CW'(1);
									state_q <= S_DEL;
								end
							end
							MODE_DEL_KEY: begin
								if (!empty) begin
									idx_q <= '0;
									state_q <= S_SRCH;
								end
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SRCH: begin
					pend_q <= issue;
					cmp_q <= idx_q;
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (hit) begin
						pend_q <= 1'b0;
						if (mode_q == MODE_INS_AFTER) begin
							if (full) begin
								state_q <= S_FIN;
							end else begin
								pos_q <= cmp_q + CW'(1);
								idx_q <= used_q;
								state_q <= S_INS;
							end
						end else begin
							pos_q <= cmp_q;
							idx_q <= cmp_q;
							state_q <= S_DEL;
						end
					end else if (!pend_q && !issue) begin
						state_q <= S_FIN;
					end
				end
				S_INS: begin
					pend_q <= issue;
					cmp_q <= rd_idx;
					if (issue) begin
						idx_q <= idx_q - CW'(1);
					end
					if (!pend_q && !issue) begin
						used_q <= used_q + CW'(1);
						state_q <= S_FIN;
					end
				end
				S_DEL: begin
					pend_q <= issue;
					cmp_q <= idx_q;
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (!pend_q && !issue) begin
						used_q <= used_q - CW'(1);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// transaction payload, result status, removed value and output registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mode_q <= mode;
					val_q <= value;
					key_q <= key;
					removed_q <= '0;
					status_q <= ST_OK;
					case (mode)
						MODE_INS_FRONT, MODE_INS_BACK: begin
							if (full) begin
								status_q <= ST_FULL;
							end
						end
						MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_KEY: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end
						end
						default: begin
							status_q <= ST_OK;
						end
					endcase
				end
			end
			S_SRCH: begin
				if (hit) begin
					if ((mode_q == MODE_INS_AFTER) && full) begin
						status_q <= ST_FULL;
					end
				end else if (!pend_q && !issue) begin
					status_q <= ST_NOT_FOUND;
				end
			end
			S_DEL: begin
				if (pend_q && (cmp_q == pos_q)) begin
					removed_q <= rd_data;
				end
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_status_q <= status_q;
					out_removed_q <= removed_q;
					out_count_q <= CNT_OUT_W'(used_q);
				end
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign removed = out_removed_q;
	assign entry_count = out_count_q;

endmodule

### sv/ole_ram.sv
// ----------------------------------------------------------------------------
// ole_ram: list entry storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ole_ram #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     wa,
	input  ole_pkg::data_t    wd,
	input  logic [AW-1:0]     ra,
	output ole_pkg::data_t    rd
);
	import ole_pkg::*;

	data_t mem [DEPTH];
	data_t rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_q <= mem[ra];
	end

	assign rd = rd_q;

endmodule
